// ===== rtl/ssph_pkg.sv =====
// Shared types, constants and codes for the spectrum smoothing and peak hold engine.
package ssph_pkg;

    localparam int SCOPE_SIZE = 512;
    localparam int ADDR_W     = $clog2(SCOPE_SIZE);
    localparam int CNT_W      = ADDR_W + 1;

    localparam int COL_W      = 9;
    localparam int LVL_W      = 16;
    localparam int TMR_W      = 10;
    localparam int COEFF_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COEFF_W-1:0]      SMOOTH_MAX  = 8'd253;
    localparam logic [COEFF_W-1:0]      SMOOTH_RST  = 8'd205;
    localparam logic [COEFF_W-1:0]      DECAY_RST   = 8'd243;
    localparam logic [TMR_W-1:0]        HOLD_RST    = 10'd125;
    localparam logic signed [LVL_W-1:0] FLOOR_RST   = -16'sd25600;
    localparam logic signed [LVL_W-1:0] CEIL_RST    = 16'sd0;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTH = 3'd0,
        REG_DECAY  = 3'd1,
        REG_HOLD   = 3'd2,
        REG_FLOOR  = 3'd3,
        REG_CEIL   = 3'd4,
        REG_ENABLE = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_TICK,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [COEFF_W-1:0]      smooth;
        logic [COEFF_W-1:0]      decay;
        logic [TMR_W-1:0]        hold;
        logic signed [LVL_W-1:0] flr;
        logic signed [LVL_W-1:0] ceil;
        logic                    enable;
    } t_cfg;

    typedef struct packed {
        logic [TMR_W-1:0]        timer;
        logic signed [LVL_W-1:0] peak;
    } t_pk_ent;

    typedef struct packed {
        logic                    en_lvl;
        logic                    en_pk;
        logic [ADDR_W-1:0]       addr;
        logic signed [LVL_W-1:0] lvl;
        t_pk_ent                 pk;
    } t_wr;

endpackage

// ===== rtl/ssph_cfg.sv =====
// Configuration register file with clear request on peak hold disable.
module ssph_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ssph_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ssph_pkg::t_cfg                  o_cfg,
    output logic                           o_clr_req
);
    import ssph_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smooth <= SMOOTH_RST;
            r_cfg.decay  <= DECAY_RST;
            r_cfg.hold   <= HOLD_RST;
            r_cfg.flr    <= FLOOR_RST;
            r_cfg.ceil   <= CEIL_RST;
            r_cfg.enable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_SMOOTH: r_cfg.smooth <= i_cfg_data[COEFF_W-1:0];
                REG_DECAY:  r_cfg.decay  <= i_cfg_data[COEFF_W-1:0];
                REG_HOLD:   r_cfg.hold   <= i_cfg_data[TMR_W-1:0];
                REG_FLOOR:  r_cfg.flr    <= $signed(i_cfg_data[LVL_W-1:0]);
                REG_CEIL:   r_cfg.ceil   <= $signed(i_cfg_data[LVL_W-1:0]);
                REG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg     = r_cfg;
    // writing 0 to the enable drops all peaks and timers
    assign o_clr_req = i_cfg_valid && (t_reg'(i_cfg_index) == REG_ENABLE) && !i_cfg_data[0];

endmodule

// ===== rtl/ssph_store.sv =====
// Column state memories: smoothed level, and peak with hold timer.
module ssph_store (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [ssph_pkg::ADDR_W-1:0]       i_rd_addr,
    input  ssph_pkg::t_wr                     i_wr,
    output logic signed [ssph_pkg::LVL_W-1:0] o_rd_lvl,
    output ssph_pkg::t_pk_ent                 o_rd_pk
);
    import ssph_pkg::*;

    logic signed [LVL_W-1:0] r_lvl_mem [SCOPE_SIZE];
    t_pk_ent                 r_pk_mem  [SCOPE_SIZE];
    logic signed [LVL_W-1:0] r_rd_lvl;
    t_pk_ent                 r_rd_pk;

    always_ff @(posedge i_clk) begin
        if (i_wr.en_lvl) begin
            r_lvl_mem[i_wr.addr] <= i_wr.lvl;
        end
        if (i_wr.en_pk) begin
            r_pk_mem[i_wr.addr] <= i_wr.pk;
        end
        // hold read data when no read is issued
        if (i_rd_en) begin
            r_rd_lvl <= r_lvl_mem[i_rd_addr];
            r_rd_pk  <= r_pk_mem[i_rd_addr];
        end
    end

    assign o_rd_lvl = r_rd_lvl;
    assign o_rd_pk  = r_rd_pk;

endmodule

// ===== rtl/ssph_dp.sv =====
// Datapath: exponential smoothing with clamp, peak capture and per-tick decay.
module ssph_dp (
    input  ssph_pkg::t_cfg                    i_cfg,
    input  logic signed [ssph_pkg::LVL_W-1:0] i_old_lvl,
    input  logic signed [ssph_pkg::LVL_W-1:0] i_new_lvl,
    input  ssph_pkg::t_pk_ent                 i_pk,
    input  logic signed [ssph_pkg::LVL_W-1:0] i_tick_flr,
    input  logic [ssph_pkg::COEFF_W-1:0]      i_tick_dcy,
    output logic signed [ssph_pkg::LVL_W-1:0] o_smooth,
    output ssph_pkg::t_pk_ent                 o_upd_pk,
    output ssph_pkg::t_pk_ent                 o_tick_pk
);
    import ssph_pkg::*;

    logic [COEFF_W-1:0]        a;
    logic signed [LVL_W:0]     diff;
    logic signed [LVL_W+9:0]   prod;
    logic signed [LVL_W+10:0]  sum;
    logic signed [LVL_W+2:0]   sh;
    logic signed [LVL_W+2:0]   flr_x;
    logic signed [LVL_W+2:0]   ceil_x;
    logic [LVL_W:0]            h;
    logic [LVL_W+COEFF_W:0]    dprod;
    logic [LVL_W+1:0]          npk;

    // a*old + (256-a)*new == 256*new + a*(old-new)
    always_comb begin
        a      = (i_cfg.smooth > SMOOTH_MAX) ? SMOOTH_MAX : i_cfg.smooth;
        diff   = {i_old_lvl[LVL_W-1], i_old_lvl} - {i_new_lvl[LVL_W-1], i_new_lvl};
        prod   = $signed({1'b0, a}) * diff;
        sum    = $signed({{3{i_new_lvl[LVL_W-1]}}, i_new_lvl, 8'h00})
               + $signed({prod[LVL_W+9], prod})
               + (LVL_W+11)'(128);
        sh     = $signed(sum[LVL_W+10:8]);
        flr_x  = {{3{i_cfg.flr[LVL_W-1]}}, i_cfg.flr};
        ceil_x = {{3{i_cfg.ceil[LVL_W-1]}}, i_cfg.ceil};
        // floor test first, so the floor wins for values below it
        if (sh < flr_x) begin
            o_smooth = i_cfg.flr;
        end else if (sh > ceil_x) begin
            o_smooth = i_cfg.ceil;
        end else begin
            o_smooth = $signed(sh[LVL_W-1:0]);
        end

        if (i_cfg.enable && (o_smooth > i_pk.peak)) begin
            o_upd_pk.timer = i_cfg.hold;
            o_upd_pk.peak  = o_smooth;
        end else begin
            o_upd_pk = i_pk;
        end
    end

    always_comb begin
        h     = {i_pk.peak[LVL_W-1], i_pk.peak} - {i_tick_flr[LVL_W-1], i_tick_flr};
        dprod = h * i_tick_dcy;
        npk   = {{2{i_tick_flr[LVL_W-1]}}, i_tick_flr}
              + {1'b0, dprod[LVL_W+COEFF_W:COEFF_W]};
        if (i_pk.timer != '0) begin
            o_tick_pk.timer = i_pk.timer - TMR_W'(1);
            o_tick_pk.peak  = i_pk.peak;
        end else if (i_pk.peak <= i_tick_flr) begin
            o_tick_pk.timer = '0;
            o_tick_pk.peak  = i_tick_flr;
        end else begin
            o_tick_pk.timer = '0;
            o_tick_pk.peak  = $signed(npk[LVL_W-1:0]);
        end
    end

endmodule

// ===== rtl/spectrum_smooth_peak_hold_top.sv =====
// Spectrum display engine: per-column smoothing and peak hold over column memories.
// A column update reads the column's entry from the memories, then computes, writes back and
// loads the result register, waiting while that register holds a result on a stalled output;
// a result waiting on a stalled output does not block a following tick or clear. A decay
// tick, taken only while peak hold is enabled, sweeps every column through the memory read
// port and holds o_stall high until the sweep is done. A clear item sweeps the peak memory
// with o_stall high; a write of 0 to peak_hold_enable holds o_stall high and queues such a
// clear. After reset the block runs a clearing pass over both memories and holds o_stall
// high until it finishes; configuration writes are taken at all times.
module spectrum_smooth_peak_hold_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [ssph_pkg::COL_W-1:0]        i_column,
    input  logic signed [ssph_pkg::LVL_W-1:0] i_level_db,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ssph_pkg::COL_W-1:0]        o_out_column,
    output logic signed [ssph_pkg::LVL_W-1:0] o_smoothed_db,
    output logic signed [ssph_pkg::LVL_W-1:0] o_peak_db,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssph_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssph_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ssph_pkg::*;

    t_cfg                    cfg;
    logic                    clr_req;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    t_wr                     wr;
    logic signed [LVL_W-1:0] rd_lvl;
    t_pk_ent                 rd_pk;
    logic signed [LVL_W-1:0] smooth;
    t_pk_ent                 upd_pk;
    t_pk_ent                 tick_pk;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_rd_v, n_rd_v;
    logic [ADDR_W-1:0]       r_widx, n_widx;
    logic                    r_clr_all, n_clr_all;
    logic signed [LVL_W-1:0] r_sw_flr, n_sw_flr;
    logic [COEFF_W-1:0]      r_sw_dcy, n_sw_dcy;
    logic                    r_clr_pend, n_clr_pend;
    logic signed [LVL_W-1:0] r_pend_flr, n_pend_flr;
    logic [COL_W-1:0]        r_upd_col, n_upd_col;
    logic signed [LVL_W-1:0] r_upd_lvl, n_upd_lvl;
    logic                    r_ov, n_ov;
    logic [COL_W-1:0]        r_oc, n_oc;
    logic signed [LVL_W-1:0] r_os, n_os;
    logic signed [LVL_W-1:0] r_op, n_op;

    ssph_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clr_req   (clr_req)
    );

    ssph_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_lvl  (rd_lvl),
        .o_rd_pk   (rd_pk)
    );

    ssph_dp u_dp (
        .i_cfg      (cfg),
        .i_old_lvl  (rd_lvl),
        .i_new_lvl  (r_upd_lvl),
        .i_pk       (rd_pk),
        .i_tick_flr (r_sw_flr),
        .i_tick_dcy (r_sw_dcy),
        .o_smooth   (smooth),
        .o_upd_pk   (upd_pk),
        .o_tick_pk  (tick_pk)
    );

    assign o_stall       = (r_state != ST_IDLE) || r_clr_pend;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ov;
    assign o_out_column  = r_oc;
    assign o_smoothed_db = r_os;
    assign o_peak_db     = r_op;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rd_v     = r_rd_v;
        n_widx     = r_widx;
        n_clr_all  = r_clr_all;
        n_sw_flr   = r_sw_flr;
        n_sw_dcy   = r_sw_dcy;
        n_clr_pend = r_clr_pend;
        n_pend_flr = r_pend_flr;
        n_upd_col  = r_upd_col;
        n_upd_lvl  = r_upd_lvl;
        n_ov       = r_ov && i_stall;
        n_oc       = r_oc;
        n_os       = r_os;
        n_op       = r_op;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr         = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (r_clr_pend) begin
                    n_state    = ST_CLEAR;
                    n_idx      = '0;
                    n_clr_all  = 1'b0;
                    n_sw_flr   = r_pend_flr;
                    n_clr_pend = 1'b0;
                end else if (i_valid) begin
                    unique case (t_op'(i_opcode))
                        OP_UPDATE: begin
                            if (int'(i_column) < SCOPE_SIZE) begin
                                rd_en     = 1'b1;
                                rd_addr   = ADDR_W'(i_column);
                                n_upd_col = i_column;
                                n_upd_lvl = i_level_db;
                                n_state   = ST_UPD;
                            end
                        end
                        OP_TICK: begin
                            if (cfg.enable) begin
                                n_state  = ST_TICK;
                                n_idx    = '0;
                                n_rd_v   = 1'b0;
                                n_sw_flr = cfg.flr;
                                n_sw_dcy = cfg.decay;
                            end
                        end
                        OP_CLEAR: begin
                            n_state   = ST_CLEAR;
                            n_idx     = '0;
                            n_clr_all = 1'b0;
                            n_sw_flr  = cfg.flr;
                        end
                        default: ;
                    endcase
                end
            end
            ST_UPD: begin
                // finish only once the result register is free
                if (!r_ov || !i_stall) begin
                    wr.en_lvl = 1'b1;
                    wr.en_pk  = 1'b1;
                    wr.addr   = ADDR_W'(r_upd_col);
                    wr.lvl    = smooth;
                    wr.pk     = upd_pk;
                    n_ov      = 1'b1;
                    n_oc      = r_upd_col;
                    n_os      = smooth;
                    n_op      = upd_pk.peak;
                    n_state   = ST_IDLE;
                end
            end
            ST_TICK: begin
                // read column idx while writing back the column read last cycle
                if (r_idx != CNT_W'(SCOPE_SIZE)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[ADDR_W-1:0];
                    n_idx   = r_idx + CNT_W'(1);
                end
                n_rd_v = (r_idx != CNT_W'(SCOPE_SIZE));
                n_widx = r_idx[ADDR_W-1:0];
                if (r_rd_v) begin
                    wr.en_pk = 1'b1;
                    wr.addr  = r_widx;
                    wr.pk    = tick_pk;
                end
                if ((r_idx == CNT_W'(SCOPE_SIZE)) && !r_rd_v) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                wr.en_lvl   = r_clr_all;
                wr.en_pk    = 1'b1;
                wr.addr     = r_idx[ADDR_W-1:0];
                wr.lvl      = '0;
                wr.pk.timer = '0;
                wr.pk.peak  = r_sw_flr;
                n_idx       = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(SCOPE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // latch the floor that holds when peak hold is switched off
        if (clr_req) begin
            n_clr_pend = 1'b1;
            n_pend_flr = cfg.flr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_idx      <= '0;
            r_rd_v     <= 1'b0;
            r_clr_all  <= 1'b1;
            r_sw_flr   <= FLOOR_RST;
            r_clr_pend <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_rd_v     <= n_rd_v;
            r_clr_all  <= n_clr_all;
            r_sw_flr   <= n_sw_flr;
            r_clr_pend <= n_clr_pend;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx     <= n_widx;
        r_sw_dcy   <= n_sw_dcy;
        r_pend_flr <= n_pend_flr;
        r_upd_col  <= n_upd_col;
        r_upd_lvl  <= n_upd_lvl;
        r_oc       <= n_oc;
        r_os       <= n_os;
        r_op       <= n_op;
    end

endmodule
